// File: sv/gcd_pkg.sv
// package for the gcd / lcm unit: transfer structs, sequencer states and defaults
// no dependencies; compile before gcd_lcm_unit
package gcd_pkg;

  // default operand width used by the datapath
  localparam int DATA_WIDTH_DEF = 64;

  // field widths of the command and result transfers
  localparam int FIELD_WIDTH = 64;

  // kind codes
  localparam logic KIND_GCD = 1'b0;
  localparam logic KIND_LCM = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [FIELD_WIDTH-1:0] operand_a;
    logic signed [FIELD_WIDTH-1:0] operand_b;
  } gcd_item_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] answer;
    logic                          div_zero;
  } gcd_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SHIFT,
    ST_DIV,
    ST_NEG,
    ST_MUL,
    ST_FINISH
  } gcd_state_t;

endpackage

// File: sv/gcd_lcm_unit.sv
// gcd / lcm unit: binary gcd, restoring divide and shift-add multiply on one shared adder
// depends on gcd_pkg
// the gcd runs first, followed by the restore of the common power of two; lcm adds a
//   divide and a multiply (skipped for a zero gcd), and a negate step when operand a is negative
// one command at a time; busy stays high from the transfer until the
//   result strobe, and the next command can be taken in the strobe cycle
// the result strobe cannot be held off; the sequencer never waits on the receiver
// rst is synchronous; it returns the sequencer to idle and drops done
module gcd_lcm_unit #(
  parameter int DATA_WIDTH = gcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  gcd_pkg::gcd_item_t  item,
  output logic                busy,
  output logic                done,
  output gcd_pkg::gcd_result_t result
);
  import gcd_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  gcd_state_t     state, state_next;
  logic [W-1:0]   p, p_next;       // gcd working value
  logic [W-1:0]   q, q_next;       // gcd working value, then the gcd itself
  logic [W-1:0]   quo, quo_next;   // dividend / quotient / multiplier
  logic [W-1:0]   rem, rem_next;   // remainder, then product accumulator
  logic [W-1:0]   amag, amag_next; // magnitude of operand a
  logic [W-1:0]   bval, bval_next; // operand b, shifted up as multiplicand
  logic [CW-1:0]  k, k_next;       // common factors of two
  logic [CW-1:0]  cnt, cnt_next;   // bit counter for divide and multiply
  logic           lcm, lcm_next;
  logic           aneg, aneg_next;
  logic           done_next;
  gcd_result_t    result_next;

  // shared adder; on subtract the top bit is the borrow
  logic [W-1:0]   alu_x, alu_y;
  logic           alu_sub;
  logic [W:0]     alu_sum;

  logic [W-1:0]   a_in, b_in, a_abs, b_abs, div_x, fin_ans;

  assign alu_sum = {1'b0, alu_x} + (alu_sub ? ~{1'b0, alu_y} : {1'b0, alu_y})
                   + (W+1)'(alu_sub);

  // input operands and their magnitudes
  assign a_in  = item.operand_a[W-1:0];
  assign b_in  = item.operand_b[W-1:0];
  assign a_abs = a_in[W-1] ? (~a_in + W'(1)) : a_in;
  assign b_abs = b_in[W-1] ? (~b_in + W'(1)) : b_in;

  // partial remainder with the next dividend bit shifted in
  assign div_x = {rem[W-2:0], quo[W-1]};

  assign busy = (state != ST_IDLE);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    p      <= p_next;
    q      <= q_next;
    quo    <= quo_next;
    rem    <= rem_next;
    amag   <= amag_next;
    bval   <= bval_next;
    k      <= k_next;
    cnt    <= cnt_next;
    lcm    <= lcm_next;
    aneg   <= aneg_next;
    result <= result_next;
  end

  // sequencer and adder operand selection
  always_comb begin
    state_next  = state;
    p_next      = p;
    q_next      = q;
    quo_next    = quo;
    rem_next    = rem;
    amag_next   = amag;
    bval_next   = bval;
    k_next      = k;
    cnt_next    = cnt;
    lcm_next    = lcm;
    aneg_next   = aneg;
    done_next   = 1'b0;
    result_next = result;
    alu_x       = p;
    alu_y       = q;
    alu_sub     = 1'b1;
    fin_ans     = lcm ? ((q == '0) ? '0 : rem) : q;

    case (state)
      ST_IDLE: begin
        if (start) begin
          p_next     = a_abs;
          q_next     = b_abs;
          amag_next  = a_abs;
          bval_next  = b_in;
          aneg_next  = a_in[W-1];
          lcm_next   = (item.kind == KIND_LCM);
          k_next     = '0;
          state_next = ST_GCD;
        end
      end

      // binary gcd: strip twos, swap so p >= q, subtract
      ST_GCD: begin
        if (p == '0) begin
          state_next = ST_SHIFT;
        end else if (q == '0) begin
          q_next     = p;
          state_next = ST_SHIFT;
        end else if (!p[0] && !q[0]) begin
          p_next = p >> 1;
          q_next = q >> 1;
          k_next = k + CW'(1);
        end else if (!p[0]) begin
          p_next = p >> 1;
        end else if (!q[0]) begin
          q_next = q >> 1;
        end else if (alu_sum[W]) begin
          p_next = q;
          q_next = p;
        end else begin
          p_next = alu_sum[W-1:0];
        end
      end

      // restore the common power of two, then pick the next phase
      ST_SHIFT: begin
        if (k != '0) begin
          q_next = q << 1;
          k_next = k - CW'(1);
        end else if (!lcm || (q == '0)) begin
          state_next = ST_FINISH;
        end else begin
          rem_next   = '0;
          quo_next   = amag;
          cnt_next   = CW'(W - 1);
          state_next = ST_DIV;
        end
      end

      // restoring division of |a| by the gcd, one quotient bit per cycle
      ST_DIV: begin
        alu_x    = div_x;
        alu_y    = q;
        rem_next = alu_sum[W] ? div_x : alu_sum[W-1:0];
        quo_next = {quo[W-2:0], ~alu_sum[W]};
        if (cnt == '0) begin
          rem_next   = '0;
          cnt_next   = CW'(W - 1);
          state_next = aneg ? ST_NEG : ST_MUL;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end

      // quotient takes the sign of operand a
      ST_NEG: begin
        alu_x      = '0;
        alu_y      = quo;
        quo_next   = alu_sum[W-1:0];
        state_next = ST_MUL;
      end

      // shift-add multiply, product wraps to W bits
      ST_MUL: begin
        alu_x     = rem;
        alu_y     = quo[0] ? bval : '0;
        alu_sub   = 1'b0;
        rem_next  = alu_sum[W-1:0];
        quo_next  = quo >> 1;
        bval_next = bval << 1;
        if (cnt == '0) begin
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end

      // load the result register and strobe it
      ST_FINISH: begin
        result_next.answer   = FIELD_WIDTH'($signed(fin_ans));
        result_next.div_zero = lcm && (q == '0);
        done_next            = 1'b1;
        state_next           = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a transfer always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not start the sequencer");

  // the strobe follows the finish step and leaves the unit ready
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(state) == ST_FINISH))
    else $error("result strobe outside the finish step");

  // a zero divide flag comes with a zero answer
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.div_zero) |-> (result.answer == '0))
    else $error("div_zero set with nonzero answer");

  // division never runs with a zero gcd
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (q != '0))
    else $error("division by a zero gcd");

  // in the gcd loop, odd minus odd always leaves p even
  a_gcd_sub: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GCD && p[0] && q[0] && !alu_sum[W] && q != '0) |=> (p[0] == 1'b0))
    else $error("odd minus odd left an odd value");

endmodule

// File: verif/tb_gcd_lcm_unit.sv
`timescale 1ns / 100ps
// testbench for gcd_lcm_unit: directed and random gcd / lcm commands, checked against
// an in-bench model of the expected answer and zero-divide flag
// depends on gcd_pkg and gcd_lcm_unit
module tb_gcd_lcm_unit;
  import gcd_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - DW);
  localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
  localparam int RANDOM_CMDS = 1527;
  // commands in this window go out back to back with no gaps
  localparam int QUIET_LO = 600;
  localparam int QUIET_HI = 900;
  // longest gcd plus lcm tail, with margin, for the quiet period at the end
  localparam int DRAIN_CYCLES = 4 * DW + 2 * DW + 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  gcd_item_t   item = '0;
  logic        busy;
  logic        done;
  gcd_result_t result;

  gcd_item_t   cmd_q[$];
  gcd_result_t awaited_answers[$];
  gcd_result_t want;
  logic        took_cmd = 1'b0;
  int          gap_left = 0;
  int          issued = 0;
  int          accepted = 0;
  int          checked = 0;
  int          mismatches = 0;
  int          n_gcd = 0;
  int          n_lcm = 0;
  int          n_div_zero = 0;

  gcd_lcm_unit #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // reset held from the start, released on a falling edge
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // sign bit of a word at the datapath width
  function automatic logic word_neg(input logic [63:0] v);
    return v[DW-1];
  endfunction

  // magnitude of a word, no overflow for the most negative value
  function automatic logic [63:0] word_mag(input logic [63:0] v);
    logic [63:0] w;
    w = v & WMASK;
    return word_neg(w) ? ((64'd0 - w) & WMASK) : w;
  endfunction

  // expected answer: euclid on magnitudes, exact divide by the gcd, wrapping multiply
  function automatic gcd_result_t calc_gcd_lcm(input gcd_item_t it);
    logic [63:0] a, b, p, q, r, quo, ans;
    gcd_result_t res;
    a = it.operand_a & WMASK;
    b = it.operand_b & WMASK;
    p = word_mag(a);
    q = word_mag(b);
    while (q != 64'd0) begin
      r = p % q;
      p = q;
      q = r;
    end
    res.div_zero = 1'b0;
    if (it.kind == KIND_GCD) begin
      ans = p & WMASK;
    end else if (p == 64'd0) begin
      ans = 64'd0;
      res.div_zero = 1'b1;
    end else begin
      quo = word_mag(a) / p;
      if (word_neg(a)) begin
        quo = (64'd0 - quo) & WMASK;
      end
      ans = (quo * b) & WMASK;
    end
    res.answer = word_neg(ans) ? (ans | ~WMASK) : ans;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_cmd(input logic k, input logic [63:0] a, input logic [63:0] b);
    gcd_item_t it;
    it.kind = k;
    it.operand_a = a;
    it.operand_b = b;
    cmd_q.push_back(it);
  endtask

  // operand mix: full random, small, negative, powers of two, edge values
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'($urandom_range(0, 1000));
      1: v = 64'd0 - 64'($urandom_range(1, 1000));
      2: v = 64'd1 << $urandom_range(0, 63);
      3: begin
        case ($urandom_range(0, 5))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = {64{1'b1}};
          3: v = MINV;
          4: v = MAXV;
          default: v = MINV + 64'd1;
        endcase
      end
      4: begin
        v = {$urandom, $urandom} >> $urandom_range(1, 62);
        if ($urandom_range(0, 1) == 1) begin
          v = 64'd0 - v;
        end
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // random pair, often sharing a large common factor so the gcd is non-trivial
  task automatic queue_random_cmd();
    logic [63:0] g, a, b;
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 45) begin
      g = 64'($urandom_range(1, 1 << 16)) << $urandom_range(0, 24);
      a = g * 64'($urandom_range(0, 1 << 20));
      b = g * 64'($urandom_range(0, 1 << 20));
      if ($urandom_range(0, 1) == 1) a = 64'd0 - a;
      if ($urandom_range(0, 1) == 1) b = 64'd0 - b;
    end else if (mode < 55) begin
      a = pick_operand();
      case ($urandom_range(0, 2))
        0: b = a;
        1: b = 64'd0 - a;
        default: b = a * 64'($urandom_range(2, 50));
      endcase
    end else begin
      a = pick_operand();
      b = pick_operand();
    end
    queue_cmd($urandom_range(0, 1) == 1 ? KIND_LCM : KIND_GCD, a, b);
  endtask

  // driver: a new command goes out, after any random gap, when none is pending or the last one transferred
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_cmd) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        item <= cmd_q.pop_front();
        start <= 1'b1;
        issued <= issued + 1;
        if (issued >= QUIET_LO && issued < QUIET_HI) begin
          gap_left <= 0;
        end else if ($urandom_range(0, 99) < 15) begin
          gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(1, 500)
                                                  : $urandom_range(1, 4);
        end else begin
          gap_left <= 0;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result strobes, then record the command transferred at this edge
  always @(posedge clk) begin
    took_cmd <= start && !busy && !rst;
    if (!rst) begin
      if (done) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch($sformatf("result strobe with nothing awaited, answer %h",
                                    result.answer));
        end else begin
          want = awaited_answers.pop_front();
          checked++;
          if (want.div_zero) n_div_zero++;
          if (result.answer !== want.answer) begin
            report_mismatch($sformatf("answer %h, wanted %h", result.answer, want.answer));
          end
          if (result.div_zero !== want.div_zero) begin
            report_mismatch($sformatf("div_zero %b, wanted %b",
                                      result.div_zero, want.div_zero));
          end
        end
      end
      if (start && !busy) begin
        awaited_answers.push_back(calc_gcd_lcm(item));
        accepted++;
        if (item.kind == KIND_GCD) n_gcd++;
        else n_lcm++;
      end
    end
  end

  // stimulus and end of run
  initial begin
    // zeros on either side, both kinds
    queue_cmd(KIND_GCD, 64'd0, 64'd0);
    queue_cmd(KIND_LCM, 64'd0, 64'd0);
    queue_cmd(KIND_GCD, 64'd0, 64'd7);
    queue_cmd(KIND_GCD, 64'd0 - 64'd9, 64'd0);
    queue_cmd(KIND_LCM, 64'd0, 64'd0 - 64'd5);
    queue_cmd(KIND_LCM, 64'd6, 64'd0);
    // most negative operand: gcd magnitude wraps, exact divide gives -1
    queue_cmd(KIND_GCD, MINV, 64'd0);
    queue_cmd(KIND_GCD, MINV, MINV);
    queue_cmd(KIND_GCD, 64'd0, MINV);
    queue_cmd(KIND_LCM, MINV, MINV);
    queue_cmd(KIND_LCM, MINV, 64'd0);
    queue_cmd(KIND_LCM, MINV, MAXV);
    queue_cmd(KIND_LCM, {64{1'b1}}, MINV);
    // largest positive values, wrapping products
    queue_cmd(KIND_GCD, MAXV, MINV);
    queue_cmd(KIND_GCD, MAXV, MAXV);
    queue_cmd(KIND_LCM, MAXV, MAXV);
    queue_cmd(KIND_GCD, MAXV, MAXV - 64'd1);
    queue_cmd(KIND_LCM, MAXV, MAXV - 64'd1);
    // signs and common factors of two
    queue_cmd(KIND_GCD, {64{1'b1}}, {64{1'b1}});
    queue_cmd(KIND_LCM, 64'd0 - 64'd12, 64'd18);
    queue_cmd(KIND_LCM, 64'd12, 64'd0 - 64'd18);
    queue_cmd(KIND_GCD, 64'd48 << 40, 64'd36 << 40);
    queue_cmd(KIND_LCM, 64'd1 << 62, MINV);
    repeat (RANDOM_CMDS) queue_random_cmd();

    while (cmd_q.size() != 0 || start || awaited_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d commands (%0d gcd, %0d lcm), %0d results checked",
             accepted, n_gcd, n_lcm, checked);
    $display("zero-divide flags seen: %0d, mismatches: %0d", n_div_zero, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80000000;
    $display("watchdog expired with %0d results still awaited", awaited_answers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
sv/gcd_pkg.sv
sv/gcd_lcm_unit.sv
verif/tb_gcd_lcm_unit.sv
